/* rtl/core/vrbs_pkg.sv */
`default_nettype none

package vrbs_pkg;

    // Field widths shared by the channels, the multiplier and the top level.
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int FRIC_W = 16;
    localparam int IDX_W  = 2;

    typedef logic signed [WORD_W-1:0]     word_t;
    typedef logic [WORD_W-1:0]            uword_t;
    typedef word_t                        vec3_t [3];
    typedef logic signed [WORD_W:0]       mul_a_t;
    typedef logic signed [2*WORD_W+1:0]   prod_t;
    typedef logic signed [WORD_W+3:0]     wide_t;

    // Command codes carried on the item channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_FORCE   = 3'd0,
        CMD_TORQUE  = 3'd1,
        CMD_SET_POS = 3'd2,
        CMD_SET_ROT = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_INV_MASS = 2'd0,
        REG_FRICTION = 2'd1,
        REG_DT_SQ    = 2'd2
    } reg_idx_t;

    localparam uword_t             INV_MASS_RST = 32'd65536;
    localparam logic [FRIC_W-1:0]  FRICTION_RST = 16'd3277;
    localparam uword_t             DT_SQ_RST    = 32'd1193046;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // True when a wide sum does not fit a signed word.
    function automatic logic wide_ovf(input wide_t v);
        logic [4:0] top;
        top = v[WORD_W+3:WORD_W-1];
        return !((top == '0) || (top == '1));
    endfunction

    // Clip a wide sum to the signed word range.
    function automatic word_t wide_sat(input wide_t v);
        word_t r;
        if (!wide_ovf(v))
        begin
            r = v[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W+3] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/vrbs_in_if.sv */
`default_nettype none

interface vrbs_in_if;
    import vrbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic                force_mode;
    word_t               value_x;
    word_t               value_y;
    word_t               value_z;

    modport source (
        output valid, command, force_mode, value_x, value_y, value_z,
        input  ready
    );

    modport sink (
        input  valid, command, force_mode, value_x, value_y, value_z,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/core/vrbs_out_if.sv */
`default_nettype none

interface vrbs_out_if;
    import vrbs_pkg::*;

    logic    valid;
    logic    ready;
    word_t   position_x;
    word_t   position_y;
    word_t   position_z;
    word_t   rotation_x;
    word_t   rotation_y;
    word_t   rotation_z;
    logic    saturated;

    modport source (
        output valid, position_x, position_y, position_z,
               rotation_x, rotation_y, rotation_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, position_x, position_y, position_z,
               rotation_x, rotation_y, rotation_z, saturated,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/core/vrbs_mul.sv */
`default_nettype none

module vrbs_mul (
    input  wire logic             clk,
    input  wire vrbs_pkg::mul_a_t a,
    input  wire vrbs_pkg::uword_t b,
    output vrbs_pkg::prod_t       p
);
    import vrbs_pkg::*;

    mul_a_t b_ext;

    // The unsigned operand is widened by one zero bit so the product is signed.
    assign b_ext = $signed({1'b0, b});

    // Registered signed product, one result per cycle.
    always_ff @(posedge clk)
    begin
        p <= prod_t'(a) * prod_t'(b_ext);
    end

endmodule

`default_nettype wire

/* rtl/core/verlet_rigid_body_step_top.sv */
`default_nettype none

// Rigid body stepper: keeps one body's position and rotation in Q16.16 and
// advances them by position Verlet integration with velocity damping. Each
// item on the command channel gives exactly one result with the position and
// rotation after it and a flag that is set when any sum or update clipped.
// Force and torque pushes and the two set commands go through S_CMD and then
// S_DONE; a tick goes through S_PREP to S_UPD for each axis and then S_DONE,
// because all six axes go one after another through a single shared 33 x 33 bit
// multiplier, six sequencer steps per axis (three products and their
// saturation). S_DONE registers the result once the output register is free.
// The next item is taken the cycle after the result is registered, while that
// result still waits in the output register. Configuration writes are taken
// in any cycle and must only be made while the block is idle.
module verlet_rigid_body_step_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    vrbs_in_if.sink                      items,
    vrbs_out_if.source                   results,
    input  wire logic                    cfg_we,
    input  wire logic [vrbs_pkg::IDX_W-1:0] cfg_index,
    input  wire vrbs_pkg::uword_t        cfg_data
);
    import vrbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_PREP,
        S_MUL_A,
        S_ACC,
        S_MUL_B,
        S_MUL_C,
        S_UPD,
        S_DONE
    } state_t;

    state_t               state_reg;

    // Configuration registers.
    uword_t               inv_mass_reg;
    logic [FRIC_W-1:0]    fric_reg;
    uword_t               dt_sq_reg;

    // Body state, one word per axis.
    vec3_t                cforce_reg;
    vec3_t                iforce_reg;
    vec3_t                ctorque_reg;
    vec3_t                itorque_reg;
    vec3_t                pos_now_reg;
    vec3_t                pos_prev_reg;
    vec3_t                rot_now_reg;
    vec3_t                rot_prev_reg;
    vec3_t                lin_vel_reg;
    vec3_t                ang_vel_reg;

    // Latched item and sequencer position.
    logic [CMD_W-1:0]     cmd_reg;
    logic                 mode_reg;
    vec3_t                val_reg;
    logic                 rot_sel_reg;
    logic [1:0]           axis_reg;
    logic                 flag_reg;

    // Per-axis working registers of a tick.
    word_t                total_reg;
    word_t                vel_reg;
    word_t                accel_reg;
    word_t                step_reg;

    // Output register.
    logic                 out_valid_reg;
    word_t                out_pos_reg [3];
    word_t                out_rot_reg [3];
    logic                 out_sat_reg;

    // Shared multiplier.
    mul_a_t               mul_a;
    uword_t               mul_b;
    prod_t                prod;

    vrbs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Operand selection follows the sequencer step.
    always_comb
    begin
        unique case (state_reg)
            S_MUL_A:
            begin
                mul_a = mul_a_t'(total_reg);
                mul_b = inv_mass_reg;
            end
            S_MUL_B:
            begin
                mul_a = mul_a_t'(accel_reg);
                mul_b = dt_sq_reg;
            end
            default:
            begin
                mul_a = mul_a_t'(vel_reg);
                mul_b = uword_t'(fric_reg);
            end
        endcase
    end

    // Operands of the axis under work.
    word_t cur_now;
    word_t cur_prev;
    word_t cur_csum;
    word_t cur_isum;

    always_comb
    begin
        if (rot_sel_reg)
        begin
            cur_now  = rot_now_reg[axis_reg];
            cur_prev = rot_prev_reg[axis_reg];
            cur_csum = ctorque_reg[axis_reg];
            cur_isum = itorque_reg[axis_reg];
        end
        else
        begin
            cur_now  = pos_now_reg[axis_reg];
            cur_prev = pos_prev_reg[axis_reg];
            cur_csum = cforce_reg[axis_reg];
            cur_isum = iforce_reg[axis_reg];
        end
    end

    // Tick arithmetic around the multiplier.
    wide_t total_wide;
    wide_t vel_wide;
    logic  accel_ovf;
    word_t accel_sat;
    word_t damp;
    wide_t new_wide;

    assign total_wide = wide_t'(cur_csum) + wide_t'(cur_isum);
    assign vel_wide   = wide_t'(cur_now) - wide_t'(cur_prev);
    assign accel_ovf  = !((prod[2*WORD_W+1:WORD_W+FRIC_W-1] == '0) ||
                          (prod[2*WORD_W+1:WORD_W+FRIC_W-1] == '1));
    assign accel_sat  = accel_ovf ? (prod[2*WORD_W+1] ? WORD_MIN : WORD_MAX)
                                  : $signed(prod[WORD_W+FRIC_W-1:FRIC_W]);
    assign damp       = $signed(prod[WORD_W+FRIC_W-1:FRIC_W]);
    assign new_wide   = wide_t'(cur_now) + wide_t'(vel_reg) + wide_t'(step_reg)
                      - wide_t'(damp);

    // Push and set lanes, one per axis.
    vec3_t push_sum;
    vec3_t set_prev;
    logic [2:0] push_ovf;
    logic [2:0] set_ovf;

    always_comb
    begin
        wide_t ps;
        wide_t ss;
        word_t base;
        word_t vel;
        for (int i = 0; i < 3; i++)
        begin
            if (cmd_reg == CMD_TORQUE)
            begin
                base = mode_reg ? ctorque_reg[i] : itorque_reg[i];
            end
            else
            begin
                base = mode_reg ? cforce_reg[i] : iforce_reg[i];
            end
            vel = (cmd_reg == CMD_SET_ROT) ? ang_vel_reg[i] : lin_vel_reg[i];
            ps = wide_t'(base) + wide_t'(val_reg[i]);
            ss = wide_t'(val_reg[i]) - wide_t'(vel);
            push_sum[i] = wide_sat(ps);
            push_ovf[i] = wide_ovf(ps);
            set_prev[i] = wide_sat(ss);
            set_ovf[i]  = wide_ovf(ss);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= INV_MASS_RST;
            fric_reg     <= FRICTION_RST;
            dt_sq_reg    <= DT_SQ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INV_MASS: inv_mass_reg <= cfg_data;
                REG_FRICTION: fric_reg     <= cfg_data[FRIC_W-1:0];
                REG_DT_SQ:    dt_sq_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer, body state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rot_sel_reg   <= 1'b0;
            axis_reg      <= 2'd0;
            flag_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cforce_reg[i]   <= '0;
                iforce_reg[i]   <= '0;
                ctorque_reg[i]  <= '0;
                itorque_reg[i]  <= '0;
                pos_now_reg[i]  <= '0;
                pos_prev_reg[i] <= '0;
                rot_now_reg[i]  <= '0;
                rot_prev_reg[i] <= '0;
                lin_vel_reg[i]  <= '0;
                ang_vel_reg[i]  <= '0;
            end
        end
        else
        begin
            // A taken result frees the register; the final step reloads it itself.
            if (results.valid && results.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (items.valid)
                    begin
                        cmd_reg     <= items.command;
                        mode_reg    <= items.force_mode;
                        val_reg[0]  <= items.value_x;
                        val_reg[1]  <= items.value_y;
                        val_reg[2]  <= items.value_z;
                        flag_reg    <= 1'b0;
                        rot_sel_reg <= 1'b0;
                        axis_reg    <= 2'd0;
                        state_reg   <= (items.command == CMD_TICK) ? S_PREP : S_CMD;
                    end
                end

                // Pushes and sets work on all three axes at once.
                S_CMD:
                begin
                    unique case (cmd_reg)
                        CMD_FORCE:
                        begin
                            if (mode_reg) cforce_reg <= push_sum;
                            else          iforce_reg <= push_sum;
                            flag_reg <= |push_ovf;
                        end
                        CMD_TORQUE:
                        begin
                            if (mode_reg) ctorque_reg <= push_sum;
                            else          itorque_reg <= push_sum;
                            flag_reg <= |push_ovf;
                        end
                        CMD_SET_POS:
                        begin
                            pos_prev_reg <= set_prev;
                            pos_now_reg  <= val_reg;
                            flag_reg     <= |set_ovf;
                        end
                        CMD_SET_ROT:
                        begin
                            rot_prev_reg <= set_prev;
                            rot_now_reg  <= val_reg;
                            flag_reg     <= |set_ovf;
                        end
                        default: ;
                    endcase
                    state_reg <= S_DONE;
                end

                // Total push and velocity of the axis.
                S_PREP:
                begin
                    total_reg <= wide_sat(total_wide);
                    vel_reg   <= wide_sat(vel_wide);
                    flag_reg  <= flag_reg | wide_ovf(total_wide) | wide_ovf(vel_wide);
                    state_reg <= S_MUL_A;
                end

                S_MUL_A:
                begin
                    state_reg <= S_ACC;
                end

                // Acceleration from the product with inverse mass.
                S_ACC:
                begin
                    accel_reg <= accel_sat;
                    flag_reg  <= flag_reg | accel_ovf;
                    state_reg <= S_MUL_B;
                end

                S_MUL_B:
                begin
                    state_reg <= S_MUL_C;
                end

                // Step term from acceleration times step time squared.
                S_MUL_C:
                begin
                    step_reg  <= $signed(prod[2*WORD_W-1:WORD_W]);
                    state_reg <= S_UPD;
                end

                // Write back the axis and move on.
                S_UPD:
                begin
                    flag_reg <= flag_reg | wide_ovf(new_wide);
                    if (rot_sel_reg)
                    begin
                        rot_now_reg[axis_reg]  <= wide_sat(new_wide);
                        rot_prev_reg[axis_reg] <= cur_now;
                        ang_vel_reg[axis_reg]  <= vel_reg;
                        itorque_reg[axis_reg]  <= '0;
                    end
                    else
                    begin
                        pos_now_reg[axis_reg]  <= wide_sat(new_wide);
                        pos_prev_reg[axis_reg] <= cur_now;
                        lin_vel_reg[axis_reg]  <= vel_reg;
                        iforce_reg[axis_reg]   <= '0;
                    end
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg <= 2'd0;
                        if (rot_sel_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            rot_sel_reg <= 1'b1;
                            state_reg   <= S_PREP;
                        end
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_PREP;
                    end
                end

                // Load the result once the output register is free.
                S_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_pos_reg   <= pos_now_reg;
                        out_rot_reg   <= rot_now_reg;
                        out_sat_reg   <= flag_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign items.ready        = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.position_x = out_pos_reg[0];
    assign results.position_y = out_pos_reg[1];
    assign results.position_z = out_pos_reg[2];
    assign results.rotation_x = out_rot_reg[0];
    assign results.rotation_y = out_rot_reg[1];
    assign results.rotation_z = out_rot_reg[2];
    assign results.saturated  = out_sat_reg;

`ifndef SYNTHESIS
    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("item accepted while another is in work");

    // The axis counter stays within the three axes.
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    // A tick leaves all impulse sums cleared.
    a_impulse_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && rot_sel_reg && axis_reg == 2'd2) |=>
        (iforce_reg[0] == '0 && iforce_reg[1] == '0 && iforce_reg[2] == '0 &&
         itorque_reg[0] == '0 && itorque_reg[1] == '0 && itorque_reg[2] == '0))
        else $error("impulse sums not cleared by tick");

    // A result appears only from the final sequencer step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire

/* tb/sv/vrbs_pose_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result channels of the rigid body stepper, keeps
// its own copy of the body state and configuration, and compares every
// result transfer with the pose that the matching command should produce.
module vrbs_pose_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    vrbs_in_if                                items,
    vrbs_out_if                               results,
    input  wire logic                         cfg_we,
    input  wire logic [vrbs_pkg::IDX_W-1:0]   cfg_index,
    input  wire vrbs_pkg::uword_t             cfg_data,
    output int                                outstanding,
    output int                                mismatches
);
    import vrbs_pkg::*;

    localparam int LINEAR  = 0;
    localparam int ANGULAR = 1;
    localparam int MAX_REPORTS = 200;

    // One expected result: three position and three rotation words, then the flag.
    typedef struct packed {
        logic [5:0][WORD_W-1:0] coord;
        logic                   clip;
    } pose_t;

    pose_t expected_poses[$];
    pose_t want;
    pose_t got;
    int    k;

    // Configuration copy.
    uword_t             inv_mass;
    logic [FRIC_W-1:0]  friction;
    uword_t             dt_sq;

    // Body state, indexed by group (linear or angular) and axis.
    word_t axis_now    [2][3];
    word_t axis_prev   [2][3];
    word_t axis_vel    [2][3];
    word_t const_sum   [2][3];
    word_t impulse_sum [2][3];

    // Set when any sum or update clips while the current command is predicted.
    logic clipped;

    // Clip an exact value to the signed word range and note the clip.
    function word_t clip_word(input longint v);
        word_t r;
        if (v > longint'(WORD_MAX))
        begin
            clipped = 1'b1;
            r = WORD_MAX;
        end
        else if (v < longint'(WORD_MIN))
        begin
            clipped = 1'b1;
            r = WORD_MIN;
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function string coord_label(input int idx);
        string s;
        case (idx)
            0: s = "position_x";
            1: s = "position_y";
            2: s = "position_z";
            3: s = "rotation_x";
            4: s = "rotation_y";
            default: s = "rotation_z";
        endcase
        return s;
    endfunction

    task report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches = mismatches + 1;
    endtask

    // One Verlet step of a group: acceleration from the summed pushes, velocity
    // from the last two values, then the damped move of each axis.
    task integrate_axes(input int g);
        word_t  total;
        word_t  accel;
        word_t  speed;
        word_t  cur;
        longint step_term;
        longint damping;
        int     i;
        for (i = 0; i < 3; i++)
        begin
            total = clip_word(longint'(const_sum[g][i]) + longint'(impulse_sum[g][i]));
            accel = clip_word((longint'(total) * longint'({32'd0, inv_mass})) >>> 16);
            cur   = axis_now[g][i];
            speed = clip_word(longint'(cur) - longint'(axis_prev[g][i]));
            step_term = (longint'(accel) * longint'({32'd0, dt_sq})) >>> 32;
            damping   = (longint'(speed) * longint'({48'd0, friction})) >>> 16;
            impulse_sum[g][i] = '0;
            axis_vel[g][i]    = speed;
            axis_prev[g][i]   = cur;
            axis_now[g][i]    = clip_word(longint'(cur) + longint'(speed)
                                          + step_term - damping);
        end
    endtask

    // Apply one command to the state copy and queue the pose it leaves.
    task predict_pose(input logic [CMD_W-1:0] cmd, input logic constant_push,
                      input word_t vx, input word_t vy, input word_t vz);
        word_t operand[3];
        pose_t p;
        int    g;
        int    i;
        operand[0] = vx;
        operand[1] = vy;
        operand[2] = vz;
        clipped = 1'b0;
        g = (cmd == CMD_TORQUE || cmd == CMD_SET_ROT) ? ANGULAR : LINEAR;
        case (cmd)
            CMD_FORCE, CMD_TORQUE:
            begin
                for (i = 0; i < 3; i++)
                begin
                    if (constant_push)
                    begin
                        const_sum[g][i] = clip_word(longint'(const_sum[g][i])
                                                    + longint'(operand[i]));
                    end
                    else
                    begin
                        impulse_sum[g][i] = clip_word(longint'(impulse_sum[g][i])
                                                      + longint'(operand[i]));
                    end
                end
            end
            CMD_SET_POS, CMD_SET_ROT:
            begin
                // The previous value moves along so the velocity survives.
                for (i = 0; i < 3; i++)
                begin
                    axis_prev[g][i] = clip_word(longint'(operand[i])
                                                - longint'(axis_vel[g][i]));
                    axis_now[g][i]  = operand[i];
                end
            end
            CMD_TICK:
            begin
                integrate_axes(LINEAR);
                integrate_axes(ANGULAR);
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < 3; i++)
        begin
            p.coord[i]     = axis_now[LINEAR][i];
            p.coord[3 + i] = axis_now[ANGULAR][i];
        end
        p.clip = clipped;
        expected_poses = {expected_poses, p};
    endtask

    // Channel monitor: results are matched before the command of the same
    // edge is predicted, since a command never completes on its own edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass = INV_MASS_RST;
            friction = FRICTION_RST;
            dt_sq    = DT_SQ_RST;
            for (int g = 0; g < 2; g++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    axis_now[g][i]    = '0;
                    axis_prev[g][i]   = '0;
                    axis_vel[g][i]    = '0;
                    const_sum[g][i]   = '0;
                    impulse_sum[g][i] = '0;
                end
            end
            expected_poses.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    report_mismatch("result transfer with no command pending");
                end
                else
                begin
                    want = expected_poses.pop_front();
                    got.coord[0] = results.position_x;
                    got.coord[1] = results.position_y;
                    got.coord[2] = results.position_z;
                    got.coord[3] = results.rotation_x;
                    got.coord[4] = results.rotation_y;
                    got.coord[5] = results.rotation_z;
                    got.clip     = results.saturated;
                    for (k = 0; k < 6; k++)
                    begin
                        if (got.coord[k] !== want.coord[k])
                        begin
                            report_mismatch($sformatf("%s got %h expected %h",
                                coord_label(k), got.coord[k], want.coord[k]));
                        end
                    end
                    if (got.clip !== want.clip)
                    begin
                        report_mismatch($sformatf("saturated got %b expected %b",
                                                  got.clip, want.clip));
                    end
                end
            end

            if (items.valid && items.ready)
            begin
                predict_pose(items.command, items.force_mode,
                             items.value_x, items.value_y, items.value_z);
            end

            // Register writes; an index past the last register is ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INV_MASS: inv_mass = cfg_data;
                    REG_FRICTION: friction = cfg_data[FRIC_W-1:0];
                    REG_DT_SQ:    dt_sq    = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            outstanding <= expected_poses.size();
        end
    end

endmodule

/* tb/sv/verlet_rigid_body_step_top_test.sv */
`timescale 1ns / 100ps

// Drives commands and configuration into the rigid body stepper, applies
// random back-pressure on the results, and gives the verdict from the
// checker's mismatch count.
module verlet_rigid_body_step_top_test;
    import vrbs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic [IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 235;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    uword_t cfg_data;

    int outstanding;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;

    vrbs_in_if  cmd_ch ();
    vrbs_out_if pose_ch ();

    verlet_rigid_body_step_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (cmd_ch),
        .results   (pose_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vrbs_pose_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (cmd_ch),
        .results     (pose_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, well above the slowest correct run.
    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    // Result side back-pressure.
    initial
    begin
        pose_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            pose_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Operand mix: extremes, full range and values near zero.
    function word_t pick_word();
        word_t w;
        case ($urandom_range(9))
            0: w = WORD_MAX;
            1: w = WORD_MIN;
            2, 3: w = $urandom;
            default:
            begin
                w = $urandom_range(2097152);
                w = w - 32'sd1048576;
            end
        endcase
        return w;
    endfunction

    // One command transfer, preceded by random idle cycles.
    task push_command(input logic [CMD_W-1:0] cmd, input logic mode,
                      input word_t vx, input word_t vy, input word_t vz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.force_mode <= mode;
        cmd_ch.value_x    <= vx;
        cmd_ch.value_y    <= vy;
        cmd_ch.value_z    <= vz;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task random_command();
        logic [CMD_W-1:0] cmd;
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            cmd = CMD_TICK;
        else if (roll < 55)
            cmd = CMD_FORCE;
        else if (roll < 75)
            cmd = CMD_TORQUE;
        else if (roll < 85)
            cmd = CMD_SET_POS;
        else if (roll < 95)
            cmd = CMD_SET_ROT;
        else
            cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        push_command(cmd, 1'($urandom_range(1)), pick_word(), pick_word(), pick_word());
    endtask

    // Stop sending and wait until every result has been taken.
    task drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write all registers in a row, plus one write past the last index.
    task write_regs(input uword_t mass, input logic [FRIC_W-1:0] fric,
                    input uword_t dt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INV_MASS;
        cfg_data  <= mass;
        @(posedge clk);
        cfg_index <= REG_FRICTION;
        cfg_data  <= {16'd0, fric};
        @(posedge clk);
        cfg_index <= REG_DT_SQ;
        cfg_data  <= dt;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_TICK;
        cmd_ch.force_mode <= 1'b0;
        cmd_ch.value_x    <= '0;
        cmd_ch.value_y    <= '0;
        cmd_ch.value_z    <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_INV_MASS;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset configuration: sums clipping at both
        // ends, constant and impulse pushes, sets that keep velocity, spare
        // commands and a mode bit that must be ignored.
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_FORCE, 1'b0, WORD_MAX, WORD_MIN, 32'sd65536);
        push_command(CMD_FORCE, 1'b0, WORD_MAX, WORD_MIN, -32'sd1);
        push_command(CMD_FORCE, 1'b1, 32'sd65536, -32'sd65536, '0);
        push_command(CMD_TORQUE, 1'b0, WORD_MIN, WORD_MAX, 32'sd12345);
        push_command(CMD_TORQUE, 1'b1, 32'sd65536, '0, -32'sd65536);
        push_command(CMD_TICK, 1'b1, WORD_MAX, WORD_MAX, WORD_MAX);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_SET_POS, 1'b1, WORD_MAX, WORD_MIN, '0);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_SET_ROT, 1'b0, WORD_MIN, WORD_MAX, 32'sd1);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_SET_POS, 1'b0, '0, '0, '0);
        push_command(CMD_SPARE_LO, 1'b0, WORD_MAX, WORD_MAX, WORD_MAX);
        push_command(CMD_SPARE_LO + 3'd1, 1'b1, WORD_MIN, '0, WORD_MIN);
        push_command(CMD_SPARE_HI, 1'b1, -32'sd1, -32'sd1, -32'sd1);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_SET_ROT, 1'b1, '0, '0, '0);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);
        push_command(CMD_FORCE, 1'b0, 32'sd1000000, -32'sd1000000, 32'sd7);
        push_command(CMD_TICK, 1'b0, '0, '0, '0);

        // Random part: each phase gets its own register setting, and each pair of phases an idle mix.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: write_regs(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
                1: write_regs('0, '0, '0);
                4: write_regs(INV_MASS_RST, FRICTION_RST, DT_SQ_RST);
                default: write_regs($urandom_range(32'h0004_0000),
                                    FRIC_W'($urandom_range(16'hFFFF)), $urandom);
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 63;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (ITEMS_PER_PHASE) random_command();
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
